[rtl/iprm_pkg.sv]
// Shared types, codes and helpers for the ICMP probe reply matcher.
`default_nettype none

package iprm_pkg;

  // ICMP message types and minimum ICMP header length
  localparam logic [7:0] TYPE_ECHO  = 8'd0;
  localparam logic [7:0] TYPE_TTL   = 8'd11;
  localparam int unsigned ICMP_HDR  = 8;

  // Field widths
  localparam int RTT_W  = 24;
  localparam int ADDR_W = 32;
  localparam int CFG_W  = 16;

  // Default number of exceeded replies collected per probe
  localparam int DEFAULT_MAX_PROBE_REPLIES = 3;

  // Opcodes of an input word
  localparam logic OP_BYTE      = 1'b0;
  localparam logic OP_NEW_PROBE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_PROBE_ID  = 1'b0;
  localparam logic CFG_PROBE_SEQ = 1'b1;

  // Verdict codes
  typedef enum logic [2:0] {
    VERDICT_OTHER             = 3'd0,
    VERDICT_ECHO_MATCH        = 3'd1,
    VERDICT_EXCEEDED_MATCH    = 3'd2,
    VERDICT_ECHO_MISMATCH     = 3'd3,
    VERDICT_EXCEEDED_MISMATCH = 3'd4,
    VERDICT_TRUNCATED         = 3'd5
  } verdict_t;

  // IPv4 header length in bytes from the version/IHL byte; IHL below 5 counts as 5
  function automatic logic [5:0] ihl_to_bytes(input logic [7:0] b);
    logic [3:0] ihl;
    ihl = b[3:0];
    if (ihl < 4'd5) begin
      ihl = 4'd5;
    end
    return {ihl, 2'b00};
  endfunction

endpackage

`default_nettype wire

[rtl/icmp_probe_reply_matcher.sv]
// A packet's result goes through the pending and then the output result register.
// Throughput: one byte per cycle; item_stall rises only when both the pending and
// the output result registers are full and the output is stalled.
// The average RTT is a reciprocal multiply in the stage before the output register.
// Reset (rst, synchronous) clears configuration, packet and probe state; the router
// list has no reset, entries are read only below the stored router count.
`default_nettype none

module icmp_probe_reply_matcher #(
  parameter int MAX_PROBE_REPLIES = iprm_pkg::DEFAULT_MAX_PROBE_REPLIES
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration write port
  input  wire logic                        cfg_write,
  input  wire logic                        cfg_index,
  input  wire logic [iprm_pkg::CFG_W-1:0]  cfg_data,
  // input word channel
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic                        opcode,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        last_byte,
  input  wire logic [iprm_pkg::RTT_W-1:0]  elapsed_us,
  // result word channel
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic [2:0]                       verdict,
  output logic [iprm_pkg::ADDR_W-1:0]      source_address,
  output logic [iprm_pkg::RTT_W-1:0]       round_trip_us,
  output logic                             address_is_new,
  output logic [1:0]                       replies_collected,
  output logic                             probe_done,
  output logic [iprm_pkg::RTT_W-1:0]       average_rtt_us
);

  localparam int CNT_W    = $clog2(MAX_PROBE_REPLIES + 1);
  localparam int SUM_W    = iprm_pkg::RTT_W + CNT_W;
  localparam int SHIFT_L  = $clog2(MAX_PROBE_REPLIES);
  localparam int RECIP_SH = SUM_W + SHIFT_L;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((longint'(1) << RECIP_SH) + longint'(MAX_PROBE_REPLIES) - 1) /
    longint'(MAX_PROBE_REPLIES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [CNT_W-1:0]   MAX_CNT = CNT_W'(MAX_PROBE_REPLIES);

  // configuration
  logic [iprm_pkg::CFG_W-1:0] probe_identifier;
  logic [iprm_pkg::CFG_W-1:0] probe_sequence;

  // packet state
  logic [15:0] byte_position;
  logic [5:0]  outer_header_bytes;
  logic [5:0]  inner_header_bytes;
  logic [7:0]  icmp_type;
  logic [15:0] captured_identifier;
  logic [15:0] captured_sequence;
  logic [31:0] src_shift;

  // probe state
  logic [31:0]      router_list [MAX_PROBE_REPLIES];
  logic [CNT_W-1:0] router_count;
  logic [CNT_W-1:0] matched_count;
  logic [SUM_W-1:0] rtt_sum;
  logic             probe_finished;

  // next values
  logic [15:0]      byte_position_next;
  logic [5:0]       outer_header_bytes_next;
  logic [5:0]       inner_header_bytes_next;
  logic [7:0]       icmp_type_next;
  logic [15:0]      captured_identifier_next;
  logic [15:0]      captured_sequence_next;
  logic [31:0]      src_shift_next;
  logic [CNT_W-1:0] router_count_next;
  logic [CNT_W-1:0] matched_count_next;
  logic [SUM_W-1:0] rtt_sum_next;
  logic             probe_finished_next;
  logic [MAX_PROBE_REPLIES-1:0] list_we;

  // per-word decode
  logic [5:0]  hlen_cur;
  logic [15:0] rel;
  logic [16:0] inner_off;
  logic        cap_en;
  logic [15:0] cap_off;
  logic [16:0] len;
  logic [16:0] hlen17;
  logic [31:0] src_cur;
  logic        match;
  logic        seen;
  logic        res_new;
  iprm_pkg::verdict_t res_verdict;

  // pending result stage
  logic                        p_valid;
  iprm_pkg::verdict_t          p_verdict;
  logic [31:0]                 p_source;
  logic [iprm_pkg::RTT_W-1:0]  p_rtt;
  logic                        p_new;
  logic [1:0]                  p_replies;
  logic                        p_done;
  logic [SUM_W-1:0]            p_sum;
  logic                        p_full;

  // handshake
  logic out_adv;
  logic accept;
  logic produce;
  logic [PROD_W-1:0] avg_prod;

  assign out_adv    = !result_valid || !result_stall;
  assign item_stall = p_valid && !out_adv;
  assign accept     = item_valid && !item_stall;
  assign produce    = accept && (opcode == iprm_pkg::OP_BYTE) && last_byte;

  // byte parsing and per-probe bookkeeping
  always_comb begin
    byte_position_next       = byte_position;
    outer_header_bytes_next  = outer_header_bytes;
    inner_header_bytes_next  = inner_header_bytes;
    icmp_type_next           = icmp_type;
    captured_identifier_next = captured_identifier;
    captured_sequence_next   = captured_sequence;
    src_shift_next           = src_shift;
    router_count_next        = router_count;
    matched_count_next       = matched_count;
    rtt_sum_next             = rtt_sum;
    probe_finished_next      = probe_finished;
    list_we                  = '0;
    cap_en                   = 1'b0;
    cap_off                  = '0;
    seen                     = 1'b0;
    res_new                  = 1'b0;
    res_verdict              = iprm_pkg::VERDICT_OTHER;

    // outer header length and source address
    if (byte_position == 16'd0) begin
      outer_header_bytes_next = iprm_pkg::ihl_to_bytes(data_byte);
    end else if (byte_position >= 16'd12 && byte_position <= 16'd15) begin
      src_shift_next = {src_shift[23:0], data_byte};
    end
    // address as of this byte, kept apart from the end-of-packet clear
    src_cur  = src_shift_next;
    hlen_cur = outer_header_bytes_next;
    hlen17   = 17'(hlen_cur);
    rel      = byte_position - 16'(hlen_cur);
    inner_off = {1'b0, rel} - 17'(iprm_pkg::ICMP_HDR) - 17'(inner_header_bytes);

    // type byte, then echo id/seq or embedded header
    if (byte_position != 16'd0 && byte_position == 16'(hlen_cur)) begin
      icmp_type_next = data_byte;
    end else if (byte_position != 16'd0 && byte_position > 16'(hlen_cur)) begin
      if (icmp_type == iprm_pkg::TYPE_ECHO) begin
        cap_en  = 1'b1;
        cap_off = rel;
      end else if (icmp_type == iprm_pkg::TYPE_TTL) begin
        if (rel == 16'(iprm_pkg::ICMP_HDR)) begin
          inner_header_bytes_next = iprm_pkg::ihl_to_bytes(data_byte);
        end else if (rel > 16'(iprm_pkg::ICMP_HDR) && !inner_off[16]) begin
          cap_en  = 1'b1;
          cap_off = inner_off[15:0];
        end
      end
    end

    // id/seq capture, high byte first
    if (cap_en) begin
      if (cap_off == 16'd4 || cap_off == 16'd5) begin
        captured_identifier_next = {captured_identifier[7:0], data_byte};
      end else if (cap_off == 16'd6 || cap_off == 16'd7) begin
        captured_sequence_next = {captured_sequence[7:0], data_byte};
      end
    end

    if (byte_position != 16'hFFFF) begin
      byte_position_next = byte_position + 16'd1;
    end

    // verdict at the packet's last byte
    len   = {1'b0, byte_position} + 17'd1;
    match = (captured_identifier_next == probe_identifier) &&
            (captured_sequence_next == probe_sequence);
    for (int i = 0; i < MAX_PROBE_REPLIES; i++) begin
      if (CNT_W'(i) < router_count && router_list[i] == src_cur) begin
        seen = 1'b1;
      end
    end

    if (last_byte) begin
      if (len <= hlen17) begin
        res_verdict = iprm_pkg::VERDICT_TRUNCATED;
      end else if (icmp_type_next == iprm_pkg::TYPE_ECHO) begin
        if (len < hlen17 + 17'(iprm_pkg::ICMP_HDR)) begin
          res_verdict = iprm_pkg::VERDICT_TRUNCATED;
        end else if (match) begin
          res_verdict         = iprm_pkg::VERDICT_ECHO_MATCH;
          probe_finished_next = 1'b1;
        end else begin
          res_verdict = iprm_pkg::VERDICT_ECHO_MISMATCH;
        end
      end else if (icmp_type_next == iprm_pkg::TYPE_TTL) begin
        if (len <= hlen17 + 17'(iprm_pkg::ICMP_HDR) ||
            len < hlen17 + 17'(2 * iprm_pkg::ICMP_HDR) + 17'(inner_header_bytes_next)) begin
          res_verdict = iprm_pkg::VERDICT_TRUNCATED;
        end else if (match) begin
          res_verdict = iprm_pkg::VERDICT_EXCEEDED_MATCH;
          if (!probe_finished && matched_count < MAX_CNT) begin
            if (!seen && router_count < MAX_CNT) begin
              for (int i = 0; i < MAX_PROBE_REPLIES; i++) begin
                list_we[i] = (router_count == CNT_W'(i));
              end
              router_count_next = router_count + CNT_W'(1);
              res_new           = 1'b1;
            end
            rtt_sum_next       = rtt_sum + SUM_W'(elapsed_us);
            matched_count_next = matched_count + CNT_W'(1);
            if (matched_count_next == MAX_CNT) begin
              probe_finished_next = 1'b1;
            end
          end
        end else begin
          res_verdict = iprm_pkg::VERDICT_EXCEEDED_MISMATCH;
        end
      end

      // packet done: clear packet state
      byte_position_next       = '0;
      outer_header_bytes_next  = '0;
      inner_header_bytes_next  = '0;
      icmp_type_next           = '0;
      captured_identifier_next = '0;
      captured_sequence_next   = '0;
      src_shift_next           = '0;
    end

    // new probe drops the packet and the collected replies
    if (opcode == iprm_pkg::OP_NEW_PROBE) begin
      byte_position_next       = '0;
      outer_header_bytes_next  = '0;
      inner_header_bytes_next  = '0;
      icmp_type_next           = '0;
      captured_identifier_next = '0;
      captured_sequence_next   = '0;
      src_shift_next           = '0;
      router_count_next        = '0;
      matched_count_next       = '0;
      rtt_sum_next             = '0;
      probe_finished_next      = 1'b0;
      list_we                  = '0;
    end
  end

  // configuration and parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_identifier    <= '0;
      probe_sequence      <= '0;
      byte_position       <= '0;
      outer_header_bytes  <= '0;
      inner_header_bytes  <= '0;
      icmp_type           <= '0;
      captured_identifier <= '0;
      captured_sequence   <= '0;
      src_shift           <= '0;
      router_count        <= '0;
      matched_count       <= '0;
      rtt_sum             <= '0;
      probe_finished      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          iprm_pkg::CFG_PROBE_ID:  probe_identifier <= cfg_data;
          iprm_pkg::CFG_PROBE_SEQ: probe_sequence   <= cfg_data;
        endcase
      end
      if (accept) begin
        byte_position       <= byte_position_next;
        outer_header_bytes  <= outer_header_bytes_next;
        inner_header_bytes  <= inner_header_bytes_next;
        icmp_type           <= icmp_type_next;
        captured_identifier <= captured_identifier_next;
        captured_sequence   <= captured_sequence_next;
        src_shift           <= src_shift_next;
        router_count        <= router_count_next;
        matched_count       <= matched_count_next;
        rtt_sum             <= rtt_sum_next;
        probe_finished      <= probe_finished_next;
      end
    end
  end

  // router list storage, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PROBE_REPLIES; i++) begin
      if (accept && list_we[i]) begin
        router_list[i] <= src_cur;
      end
    end
  end

  // pending result register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (produce) begin
      p_valid <= 1'b1;
    end else if (out_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      p_verdict <= res_verdict;
      p_source  <= src_cur;
      p_rtt     <= elapsed_us;
      p_new     <= res_new;
      p_replies <= 2'(matched_count_next);
      p_done    <= probe_finished_next;
      p_sum     <= rtt_sum_next;
      p_full    <= (matched_count_next == MAX_CNT);
    end
  end

  // average by reciprocal multiply: floor(sum / MAX_PROBE_REPLIES)
  assign avg_prod = PROD_W'(p_sum) * PROD_W'(RECIP);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_adv) begin
      result_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && p_valid) begin
      verdict           <= p_verdict;
      source_address    <= p_source;
      round_trip_us     <= p_rtt;
      address_is_new    <= p_new;
      replies_collected <= p_replies;
      probe_done        <= p_done;
      average_rtt_us    <= p_full ? avg_prod[RECIP_SH +: iprm_pkg::RTT_W] : '0;
    end
  end

  // never more distinct routers than matched replies
  a_routers_bounded: assert property (@(posedge clk) disable iff (rst)
    router_count <= matched_count)
    else $error("router count exceeds matched count");

  // matched count stays within the per-probe limit
  a_matched_bounded: assert property (@(posedge clk) disable iff (rst)
    matched_count <= MAX_CNT)
    else $error("matched count beyond limit");

  // probe done clears only on reset or a new probe word
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    $fell(probe_finished) |->
      ($past(rst) || $past(accept && opcode == iprm_pkg::OP_NEW_PROBE)))
    else $error("probe done cleared without new probe");

  // a new router is only reported with an exceeded match
  a_new_on_match: assert property (@(posedge clk) disable iff (rst)
    (result_valid && address_is_new) |-> (verdict == iprm_pkg::VERDICT_EXCEEDED_MATCH))
    else $error("new router flagged on other verdict");

endmodule

`default_nettype wire
